FILE: sv/sfb_pkg.sv
// Shared types, constants and helpers of the stuffed frame builder.
package sfb_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [7:0] FLAG_RESET     = 8'h7E;
  localparam logic [7:0] ESCAPE_RESET   = 8'h7D;
  localparam logic [7:0] ADDRESS_RESET  = 8'h03;
  localparam logic [7:0] STUFF_FOR_FLAG = 8'h5E;
  localparam logic [7:0] STUFF_FOR_ESC  = 8'h5D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLAG    = 2'd0,
    REG_ESCAPE  = 2'd1,
    REG_ADDRESS = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_PLAIN,
    CLS_FLAG,
    CLS_ESC
  } stuff_cls_e;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
    logic [7:0] address;
  } cfg_t;

  typedef struct packed {
    logic       first;
    logic       last;
    logic       seq;
    logic [7:0] hdr_val;
    stuff_cls_e hdr_cls;
    logic [7:0] data_val;
    stuff_cls_e data_cls;
    logic [7:0] chk_val;
    stuff_cls_e chk_cls;
  } cmd_t;

  function automatic stuff_cls_e classify(input logic [7:0] value, input cfg_t cfg);
    stuff_cls_e cls;
    if (value == cfg.flag) begin
      cls = CLS_FLAG;
    end else if (value == cfg.escape) begin
      cls = CLS_ESC;
    end else begin
      cls = CLS_PLAIN;
    end
    return cls;
  endfunction

endpackage

FILE: sv/sfb_if.sv
// Handshake interfaces for the payload input and the line byte output.
interface sfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       first_byte;
  logic       last_byte;
  logic       sequence_bit;

  modport source (output valid, payload_byte, first_byte, last_byte, sequence_bit,
                  input ready);
  modport sink   (input valid, payload_byte, first_byte, last_byte, sequence_bit,
                  output ready);
endinterface

interface sfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       frame_end;

  modport source (output valid, out_byte, run_end, frame_end, input ready);
  modport sink   (input valid, out_byte, run_end, frame_end, output ready);
endinterface

FILE: sv/sfb_front.sv
// Front end: accepts payload beats, keeps the running check, classifies bytes.
module sfb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfb_pkg::cfg_t cfg_i,
  sfb_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output sfb_pkg::cmd_t cmd_o
);
  import sfb_pkg::*;

  logic [7:0] check_q, check_d;
  logic [7:0] check_new;
  logic [7:0] control;
  logic [7:0] hdr_val;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  assign control   = {6'b0, in_i.sequence_bit, 1'b0};
  assign hdr_val   = cfg_i.address ^ control;
  assign check_new = in_i.first_byte ? in_i.payload_byte : (check_q ^ in_i.payload_byte);

  always_comb begin
    check_d = check_q;
    if (push_o) begin
      check_d = in_i.last_byte ? 8'h00 : check_new;
    end
  end

  always_comb begin
    cmd_o.first    = in_i.first_byte;
    cmd_o.last     = in_i.last_byte;
    cmd_o.seq      = in_i.sequence_bit;
    cmd_o.hdr_val  = hdr_val;
    cmd_o.hdr_cls  = classify(hdr_val, cfg_i);
    cmd_o.data_val = in_i.payload_byte;
    cmd_o.data_cls = classify(in_i.payload_byte, cfg_i);
    cmd_o.chk_val  = check_new;
    cmd_o.chk_cls  = classify(check_new, cfg_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_q <= 8'h00;
    end else begin
      check_q <= check_d;
    end
  end

endmodule

FILE: sv/sfb_queue.sv
// Short command queue between front and back end.
module sfb_queue #(
  parameter int unsigned Depth = sfb_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfb_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sfb_pkg::cmd_t pop_data_o
);
  import sfb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/sfb_back.sv
// Back end: expands each command into line bytes through an output register.
module sfb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfb_pkg::cfg_t cfg_i,
  input  logic          q_valid_i,
  input  sfb_pkg::cmd_t q_data_i,
  output logic          pop_o,
  sfb_out_if.source     out_o
);
  import sfb_pkg::*;

  typedef enum logic [3:0] {
    PH_FLAG, PH_ADDR, PH_CTRL, PH_HDR, PH_HDR2,
    PH_DATA, PH_DATA2, PH_CHK, PH_CHK2, PH_CLOSE
  } phase_e;

  phase_e     phase_q, phase_d;
  cmd_t       cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       run_end_q, run_end_d;
  logic       frame_end_q, frame_end_d;

  logic       adv;
  logic       emit;
  logic       done;
  logic       load;
  logic [7:0] byte_now;
  phase_e     phase_next;

  function automatic logic [7:0] second_byte(input stuff_cls_e cls);
    return (cls == CLS_FLAG) ? STUFF_FOR_FLAG : STUFF_FOR_ESC;
  endfunction

  assign adv  = !out_valid_q || out_o.ready;
  assign emit = adv && cur_valid_q;

  always_comb begin
    byte_now   = cfg_i.flag;
    phase_next = phase_q;
    done       = 1'b0;
    unique case (phase_q)
      PH_FLAG: begin
        byte_now   = cfg_i.flag;
        phase_next = PH_ADDR;
      end
      PH_ADDR: begin
        byte_now   = cfg_i.address;
        phase_next = PH_CTRL;
      end
      PH_CTRL: begin
        byte_now   = {6'b0, cur_q.seq, 1'b0};
        phase_next = PH_HDR;
      end
      PH_HDR: begin
        byte_now   = (cur_q.hdr_cls == CLS_PLAIN) ? cur_q.hdr_val : cfg_i.escape;
        phase_next = (cur_q.hdr_cls == CLS_PLAIN) ? PH_DATA : PH_HDR2;
      end
      PH_HDR2: begin
        byte_now   = second_byte(cur_q.hdr_cls);
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        byte_now = (cur_q.data_cls == CLS_PLAIN) ? cur_q.data_val : cfg_i.escape;
        if (cur_q.data_cls != CLS_PLAIN) begin
          phase_next = PH_DATA2;
        end else if (cur_q.last) begin
          phase_next = PH_CHK;
        end else begin
          done = 1'b1;
        end
      end
      PH_DATA2: begin
        byte_now = second_byte(cur_q.data_cls);
        if (cur_q.last) begin
          phase_next = PH_CHK;
        end else begin
          done = 1'b1;
        end
      end
      PH_CHK: begin
        byte_now   = (cur_q.chk_cls == CLS_PLAIN) ? cur_q.chk_val : cfg_i.escape;
        phase_next = (cur_q.chk_cls == CLS_PLAIN) ? PH_CLOSE : PH_CHK2;
      end
      PH_CHK2: begin
        byte_now   = second_byte(cur_q.chk_cls);
        phase_next = PH_CLOSE;
      end
      PH_CLOSE: begin
        byte_now = cfg_i.flag;
        done     = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign load  = (!cur_valid_q || (emit && done)) && q_valid_i;
  assign pop_o = load;

  always_comb begin
    phase_d     = phase_q;
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    run_end_d   = run_end_q;
    frame_end_d = frame_end_q;
    if (adv) begin
      out_valid_d = cur_valid_q;
      out_byte_d  = byte_now;
      run_end_d   = done;
      frame_end_d = (phase_q == PH_CLOSE);
    end
    if (emit) begin
      phase_d = phase_next;
      if (done) begin
        cur_valid_d = 1'b0;
      end
    end
    if (load) begin
      cur_d       = q_data_i;
      cur_valid_d = 1'b1;
      phase_d     = q_data_i.first ? PH_FLAG : PH_DATA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DATA;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    out_byte_q  <= out_byte_d;
    run_end_q   <= run_end_d;
    frame_end_q <= frame_end_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.run_end   = run_end_q;
  assign out_o.frame_end = frame_end_q;

endmodule

FILE: sv/stuffed_frame_builder.sv
// Top level of the stuffed frame builder: configuration registers and pipeline.
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    payload_byte, first_byte, last_byte, sequence_bit
//   out_o    out  valid / ready    out_byte, run_end, frame_end
//   cfg      in   cfg_we_i         cfg_idx_i, cfg_data_i
//
// The back end sequencer sends one line byte per cycle while out_o does not stall:
// a payload beat gives one byte, two when its byte is stuffed; a frame's first beat
// adds four or five header bytes and its last beat two or three check and flag bytes.
// The front end takes a beat in the cycle it arrives while the command queue has room.
// Reset clears the running check, queue and output register; no clearing pass.
// An output stall holds the output register, then fills the queue, then drops in_i.ready.
module stuffed_frame_builder #(
  parameter int unsigned QueueDepth = sfb_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sfb_in_if.sink                          in_i,
  sfb_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [sfb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sfb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import sfb_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_in, q_out;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FLAG:    cfg_d.flag    = cfg_data_i;
        REG_ESCAPE:  cfg_d.escape  = cfg_data_i;
        REG_ADDRESS: cfg_d.address = cfg_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag    <= FLAG_RESET;
      cfg_q.escape  <= ESCAPE_RESET;
      cfg_q.address <= ADDRESS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sfb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (q_push),
    .cmd_o  (q_in)
  );

  sfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  sfb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (q_out),
    .pop_o     (q_pop),
    .out_o     (out_o)
  );

endmodule

FILE: sv/sfb_checker.sv
// Port level checks of the stuffed frame builder and their bind.
module sfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       run_end_i,
  input logic       frame_end_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_byte_i) && $stable(run_end_i) && $stable(frame_end_i))
    else $error("output payload changed while stalled");

  a_close_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> run_end_i)
    else $error("closing flag not marked as end of run");

  a_quiet_after_reset: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !out_valid_i)
    else $error("output beat right after reset");

endmodule

bind stuffed_frame_builder sfb_checker u_sfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .run_end_i   (out_o.run_end),
  .frame_end_i (out_o.frame_end)
);
